// ===== rtl/sha256_pkg.sv =====
// Shared SHA-256 constants, types and round functions.
// Used by the top level, front end, queue and core of the stream hasher; depends on nothing.
`default_nettype none
package sha256_pkg;

    localparam int unsigned WordW    = 32;
    localparam int unsigned QueueDepth = 4;

    // Kind of entry handed from the front end to the core.
    localparam logic [1:0] OP_DATA   = 2'd0;
    localparam logic [1:0] OP_PAD    = 2'd1;
    localparam logic [1:0] OP_LENHI  = 2'd2;
    localparam logic [1:0] OP_LENLO  = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic        last;
        logic [31:0] word;
    } t_entry;

    typedef logic [31:0] t_word;

    function automatic t_word k_const(input logic [5:0] t);
        t_word k;
        unique case (t)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic t_word h_init(input logic [2:0] i);
        t_word h;
        unique case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
            default: h = 32'h0;
        endcase
        return h;
    endfunction

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sha256_stream_hasher_core.sv =====
// Top level of the SHA-256 stream hasher.
// Depends on sha256_pkg, sha256_front, sha256_queue and sha256_core.
//
//  Channel | Direction | Handshake      | Payload
//  message | in        | i_push/o_full  | message_word, valid_bytes, end_of_message
//  digest  | out       | o_empty/i_pop  | digest_word, digest_index, digest_last
//
// Words enter the core only while it gathers a block; a full block of 16 words is
// gathered, run through the rounds and folded into the hash before more are taken.
// The closing entries (padding, zero fill, length) finish the current block and can
// need one more full block before the eight digest words appear.
// Reset is synchronous and clears all control state. Input stalls while the queue is
// full or closing entries are still being sent; the digest waits on i_pop without losing state.
`default_nettype none
module sha256_stream_hasher_core #(
    parameter int unsigned QueueDepth = sha256_pkg::QueueDepth
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [31:0] i_message_word,
    input  wire logic [2:0]  i_valid_bytes,
    input  wire logic        i_end_of_message,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_digest_index,
    output logic             o_digest_last
);
    sha256_pkg::t_entry fe_entry, q_entry;
    logic fe_valid, q_ready, q_valid, core_take;

    sha256_front u_front (
        .i_clk, .i_rst_n, .i_push, .i_message_word, .i_valid_bytes,
        .i_end_of_message, .o_full,
        .o_entry(fe_entry), .o_entry_valid(fe_valid), .i_entry_ready(q_ready)
    );

    sha256_queue #(.Depth(QueueDepth)) u_queue (
        .i_clk, .i_rst_n, .i_wr(fe_valid), .i_data(fe_entry), .o_ready(q_ready),
        .o_valid(q_valid), .o_data(q_entry), .i_rd(core_take)
    );

    sha256_core u_core (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_entry(q_entry), .o_take(core_take),
        .o_empty, .i_pop, .o_digest_word, .o_digest_index, .o_digest_last
    );
endmodule
`default_nettype wire

// ===== rtl/sha256_front.sv =====
// Front end: accepts message words, counts bits and classifies padding.
// Depends on sha256_pkg; feeds the entry queue.
`default_nettype none
module sha256_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic [31:0]        i_message_word,
    input  wire logic [2:0]         i_valid_bytes,
    input  wire logic               i_end_of_message,
    output logic                    o_full,
    output sha256_pkg::t_entry      o_entry,
    output logic                    o_entry_valid,
    input  wire logic               i_entry_ready
);
    // Busy while the closing entries of a message are still to be sent.
    logic [63:0] r_len, n_len;
    logic [1:0]  r_tail, n_tail;   // 0 idle, 1 pad, 2 len hi, 3 len lo
    logic [63:0] len_now;
    logic [2:0]  nb;
    logic [31:0] keep, padded;

    assign o_full = (r_tail != 2'd0) || !i_entry_ready;

    always_comb begin
        nb = (i_valid_bytes > 3'd4) ? 3'd4 : i_valid_bytes;
        keep = (nb == 3'd0) ? 32'h0 : (32'hffffffff << (6'd32 - {nb, 3'b000}));
        padded = (i_message_word & keep) | (32'h80000000 >> {nb, 3'b000});
        len_now = r_len + (i_end_of_message ? {58'd0, nb, 3'b000} : 64'd32);
    end

    // Entry selection and length bookkeeping.
    always_comb begin
        n_len = r_len;
        n_tail = r_tail;
        o_entry_valid = 1'b0;
        o_entry = '0;
        priority if (r_tail == 2'd1) begin
            o_entry_valid = 1'b1;
            o_entry.op = sha256_pkg::OP_PAD;
            o_entry.word = 32'h80000000;
            if (i_entry_ready) n_tail = 2'd2;
        end else if (r_tail == 2'd2) begin
            o_entry_valid = 1'b1;
            o_entry.op = sha256_pkg::OP_LENHI;
            o_entry.word = r_len[63:32];
            if (i_entry_ready) n_tail = 2'd3;
        end else if (r_tail == 2'd3) begin
            o_entry_valid = 1'b1;
            o_entry.op = sha256_pkg::OP_LENLO;
            o_entry.last = 1'b1;
            o_entry.word = r_len[31:0];
            if (i_entry_ready) begin
                n_tail = 2'd0;
                n_len = '0;
            end
        end else if (i_push && i_entry_ready) begin
            o_entry_valid = 1'b1;
            n_len = len_now;
            if (!i_end_of_message) begin
                o_entry.op = sha256_pkg::OP_DATA;
                o_entry.word = i_message_word;
            end else if (nb == 3'd4) begin
                o_entry.op = sha256_pkg::OP_DATA;
                o_entry.word = i_message_word;
                n_tail = 2'd1;
            end else begin
                o_entry.op = sha256_pkg::OP_PAD;
                o_entry.word = padded;
                n_tail = 2'd2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_tail <= 2'd0;
        end else begin
            r_len <= n_len;
            r_tail <= n_tail;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/sha256_queue.sv =====
// Short entry queue between the front end and the compression core.
// Depends on sha256_pkg for the entry type.
`default_nettype none
module sha256_queue #(
    parameter int unsigned Depth = sha256_pkg::QueueDepth
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_wr,
    input  wire sha256_pkg::t_entry i_data,
    output logic                    o_ready,
    output logic                    o_valid,
    output sha256_pkg::t_entry      o_data,
    input  wire logic               i_rd
);
    localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
    sha256_pkg::t_entry r_mem [Depth];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          do_wr, do_rd;

    assign o_ready = (r_cnt != Depth[AW:0]);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_wr = i_wr && o_ready;
    assign do_rd = i_rd && o_valid;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_wr) r_mem[r_wp] <= i_data;
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) r_wp <= (r_wp == AW'(Depth - 1)) ? '0 : r_wp + 1'b1;
            if (do_rd) r_rp <= (r_rp == AW'(Depth - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + {{AW{1'b0}}, do_wr} - {{AW{1'b0}}, do_rd};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/sha256_core.sv =====
// Back end: gathers blocks, runs 64 rounds, and emits the digest words.
// Depends on sha256_pkg.
`default_nettype none
module sha256_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire sha256_pkg::t_entry i_entry,
    output logic                    o_take,
    output logic                    o_empty,
    input  wire logic               i_pop,
    output logic [31:0]             o_digest_word,
    output logic [2:0]              o_digest_index,
    output logic                    o_digest_last
);
    localparam logic [1:0] ST_GATHER = 2'd0;
    localparam logic [1:0] ST_ROUND  = 2'd1;
    localparam logic [1:0] ST_FINAL  = 2'd2;
    localparam logic [1:0] ST_OUT    = 2'd3;

    logic [1:0]  r_st;
    logic [31:0] r_w [16];
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [3:0]  r_pos;
    logic [5:0]  r_t;
    logic        r_last;
    logic [2:0]  r_oi;
    logic [31:0] w15, w2, s0w, s1w, wn, wt, s1, ch, s0, maj, t1, t2;
    logic        pad_word, zero_fill;

    // The closing length words must land at positions 14 and 15; zero fill before them.
    assign pad_word = (i_entry.op == sha256_pkg::OP_LENHI) && (r_pos != 4'd14);
    assign zero_fill = (r_st == ST_GATHER) && i_valid && pad_word;
    assign o_take = (r_st == ST_GATHER) && i_valid && !pad_word;

    // Schedule expansion and round datapath.
    always_comb begin
        w15 = r_w[4'(r_t - 6'd15)];
        w2  = r_w[4'(r_t - 6'd2)];
        s0w = sha256_pkg::rotr(w15, 7) ^ sha256_pkg::rotr(w15, 18) ^ (w15 >> 3);
        s1w = sha256_pkg::rotr(w2, 17) ^ sha256_pkg::rotr(w2, 19) ^ (w2 >> 10);
        wn  = r_w[r_t[3:0]] + s0w + r_w[4'(r_t - 6'd7)] + s1w;
        wt  = (r_t < 6'd16) ? r_w[r_t[3:0]] : wn;
        s1 = sha256_pkg::rotr(r_v[4], 6) ^ sha256_pkg::rotr(r_v[4], 11)
           ^ sha256_pkg::rotr(r_v[4], 25);
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1 = r_v[7] + s1 + ch + sha256_pkg::k_const(r_t) + wt;
        s0 = sha256_pkg::rotr(r_v[0], 2) ^ sha256_pkg::rotr(r_v[0], 13)
           ^ sha256_pkg::rotr(r_v[0], 22);
        maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2 = s0 + maj;
    end

    assign o_empty = (r_st != ST_OUT);
    assign o_digest_word = r_h[r_oi];
    assign o_digest_index = r_oi;
    assign o_digest_last = (r_oi == 3'd7);

    // Schedule window.
    always_ff @(posedge i_clk) begin
        if (o_take || zero_fill) r_w[r_pos] <= zero_fill ? 32'h0 : i_entry.word;
        else if (r_st == ST_ROUND && r_t >= 6'd16) r_w[r_t[3:0]] <= wn;
    end

    // Sequencer, round registers and hash state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_GATHER;
            r_pos <= '0;
            r_t <= '0;
            r_last <= 1'b0;
            r_oi <= '0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= sha256_pkg::h_init(3'(i));
                r_v[i] <= '0;
            end
        end else begin
            unique case (r_st)
                ST_GATHER: begin
                    if (o_take || zero_fill) begin
                        r_pos <= r_pos + 1'b1;
                        if (o_take) r_last <= i_entry.last;
                        if (r_pos == 4'd15) begin
                            r_st <= ST_ROUND;
                            r_t <= '0;
                            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                        end
                    end
                end
                ST_ROUND: begin
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_t <= r_t + 1'b1;
                    if (r_t == 6'd63) r_st <= ST_FINAL;
                end
                ST_FINAL: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_oi <= '0;
                    r_st <= r_last ? ST_OUT : ST_GATHER;
                end
                ST_OUT: begin
                    if (i_pop) begin
                        r_oi <= r_oi + 1'b1;
                        if (r_oi == 3'd7) begin
                            r_st <= ST_GATHER;
                            r_last <= 1'b0;
                            for (int i = 0; i < 8; i++)
                                r_h[i] <= sha256_pkg::h_init(3'(i));
                        end
                    end
                end
                default: r_st <= ST_GATHER;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/sha256_checker.sv =====
// Port-level checker for the SHA-256 stream hasher, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none
module sha256_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_empty,
    input wire logic        i_pop,
    input wire logic [2:0]  o_digest_index,
    input wire logic        o_digest_last
);
    // The last flag marks exactly the eighth word.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_digest_last == (o_digest_index == 3'd7)))
        else $error("digest_last mismatch");

    // Index steps by one after a non-final word is taken.
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && !o_digest_last) |=>
        (!o_empty && o_digest_index == $past(o_digest_index) + 3'd1))
        else $error("digest index skipped");

    // After the last word the output goes empty.
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && o_digest_last) |=> o_empty)
        else $error("digest not closed");

    // A digest always starts at index zero.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_empty) |-> (o_digest_index == 3'd0))
        else $error("digest starts mid-way");
endmodule

bind sha256_stream_hasher_core sha256_checker u_checker (
    .i_clk, .i_rst_n, .o_empty, .i_pop, .o_digest_index, .o_digest_last
);
`default_nettype wire
